@@ src/rmmmv_pkg.sv @@
// Package: widths, limits and shared types for the running min/max/mean/variance block.
package rmmmv_pkg;

   // Field widths
   localparam int SAMPLE_WIDTH = 40;
   localparam int COUNT_WIDTH  = 32;
   localparam int SUM_WIDTH    = 63;

   // Derived widths
   localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;
   localparam int STEP_WIDTH = $clog2(SAMPLE_WIDTH);
   localparam int ADD_WIDTH_A = (PROD_WIDTH > SUM_WIDTH + 1) ? PROD_WIDTH : SUM_WIDTH + 1;
   localparam int ADD_WIDTH = (ADD_WIDTH_A > COUNT_WIDTH + 1) ? ADD_WIDTH_A : COUNT_WIDTH + 1;

   // Saturation limits
   localparam logic [SUM_WIDTH-1:0]   DEV_MAX   = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [SUM_WIDTH-1:0]    sum_type;

endpackage

@@ src/running_min_max_mean_variance.sv @@
// Top level: running min, max, count, mean and Welford deviation sum over signed samples.
//
// One sample beat is taken when the block is idle; the result beat appears once the steps
// below are done and is held until taken, after which the next sample can be accepted. All
// steps use one shared adder/subtractor that serves a 40-step restoring divider (deviation over
// count, one quotient bit per cycle) and a 40-step shift-add multiplier (old deviation times
// new deviation, one multiplier bit per cycle), plus four single add steps. Minimum,
// maximum and count update at acceptance; the count and the deviation sum saturate at their
// all-ones values, and a saturated count keeps serving as the divisor.
module running_min_max_mean_variance (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rmmmv_pkg::SAMPLE_WIDTH-1:0]     req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rmmmv_pkg::SAMPLE_WIDTH-1:0]     rsp_minimum,
   output logic [rmmmv_pkg::SAMPLE_WIDTH-1:0]     rsp_maximum,
   output logic [rmmmv_pkg::COUNT_WIDTH-1:0]      rsp_count,
   output logic [rmmmv_pkg::SAMPLE_WIDTH-1:0]     rsp_mean,
   output logic [rmmmv_pkg::SUM_WIDTH-1:0]        rsp_squared_deviation_sum
);

   localparam int SW = rmmmv_pkg::SAMPLE_WIDTH;
   localparam int CW = rmmmv_pkg::COUNT_WIDTH;
   localparam int UW = rmmmv_pkg::SUM_WIDTH;
   localparam int PW = rmmmv_pkg::PROD_WIDTH;
   localparam int AW = rmmmv_pkg::ADD_WIDTH;
   localparam int TW = rmmmv_pkg::STEP_WIDTH;
   localparam logic [TW-1:0] LAST_STEP = TW'(SW - 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIFF = 8'b0000_0010,
      ST_DIV  = 8'b0000_0100,
      ST_MEAN = 8'b0000_1000,
      ST_OFF  = 8'b0001_0000,
      ST_MUL  = 8'b0010_0000,
      ST_ACC  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Statistics
   rmmmv_pkg::sample_type min_ff, min_in;
   rmmmv_pkg::sample_type max_ff, max_in;
   rmmmv_pkg::count_type  count_ff, count_in;
   rmmmv_pkg::sample_type mean_ff, mean_in;
   rmmmv_pkg::sum_type    dev_ff, dev_in;

   // Working registers
   rmmmv_pkg::sample_type sample_ff, sample_in;
   logic                  up_ff, up_in;
   rmmmv_pkg::sample_type mag_ff, mag_in;
   rmmmv_pkg::sample_type dq_ff, dq_in;
   logic [CW:0]           rem_ff, rem_in;
   rmmmv_pkg::sample_type off_ff, off_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [TW-1:0]         step_ff, step_in;

   // Shared adder/subtractor
   logic [AW-1:0] add_a;
   logic [AW-1:0] add_b;
   logic          add_sub;
   logic [AW:0]   add_sum;

   logic          accept;
   logic          up_now;
   logic [CW:0]   rem_sh;
   logic [PW-1:0] mul_sh;
   logic [AW-1:0] acc_ext;
   logic          acc_ovf;
   rmmmv_pkg::sum_type prod_sat;
   logic          ge;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign accept    = req_valid && req_ready;

   assign rsp_minimum               = min_ff;
   assign rsp_maximum               = max_ff;
   assign rsp_count                 = count_ff;
   assign rsp_mean                  = mean_ff;
   assign rsp_squared_deviation_sum = dev_ff;

   // Derive step operands
   assign up_now   = ($signed(sample_ff) >= $signed(mean_ff));
   assign rem_sh   = {rem_ff[CW-1:0], dq_ff[SW-1]};
   assign mul_sh   = {acc_ff[PW-2:0], 1'b0};
   assign acc_ext  = AW'(acc_ff);
   assign acc_ovf  = |acc_ext[AW-1:UW];
   assign prod_sat = acc_ovf ? rmmmv_pkg::DEV_MAX : acc_ext[UW-1:0];
   assign ge       = add_sum[AW];

   // Select adder operands per step
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_DIFF: begin
            add_a   = up_now ? AW'(sample_ff) : AW'(mean_ff);
            add_b   = up_now ? AW'(mean_ff) : AW'(sample_ff);
            add_sub = 1'b1;
         end
         ST_DIV: begin
            add_a   = AW'(rem_sh);
            add_b   = AW'(count_ff);
            add_sub = 1'b1;
         end
         ST_MEAN: begin
            add_a   = AW'(mean_ff);
            add_b   = AW'(dq_ff);
            add_sub = !up_ff;
         end
         ST_OFF: begin
            add_a   = AW'(mag_ff);
            add_b   = AW'(dq_ff);
            add_sub = 1'b1;
         end
         ST_MUL: begin
            add_a   = AW'(mul_sh);
            add_b   = off_ff[SW-1] ? AW'(mag_ff) : '0;
            add_sub = 1'b0;
         end
         ST_ACC: begin
            add_a   = AW'(dev_ff);
            add_b   = AW'(prod_sat);
            add_sub = 1'b0;
         end
         default: begin
            add_a   = '0;
            add_b   = '0;
            add_sub = 1'b0;
         end
      endcase
   end

   // Carry out of a subtract means no borrow
   assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW + 1)'(add_sub);

   // Sequence the steps
   always_comb begin
      state_in  = state_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      sample_in = sample_ff;
      up_in     = up_ff;
      mag_in    = mag_ff;
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      off_in    = off_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               if ((count_ff == '0) || ($signed(req_sample) < $signed(min_ff))) begin
                  min_in = req_sample;
               end
               if ((count_ff == '0) || ($signed(req_sample) > $signed(max_ff))) begin
                  max_in = req_sample;
               end
               if (count_ff != rmmmv_pkg::COUNT_MAX) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // Deviation from the old mean as sign and magnitude
            up_in    = up_now;
            mag_in   = add_sum[SW-1:0];
            dq_in    = add_sum[SW-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One restoring divide step: keep the difference when no borrow
            rem_in  = ge ? add_sum[CW:0] : rem_sh;
            dq_in   = {dq_ff[SW-2:0], ge};
            step_in = step_ff + TW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            mean_in  = add_sum[SW-1:0];
            state_in = ST_OFF;
         end
         ST_OFF: begin
            // Deviation from the new mean keeps the sign, magnitude mag - q
            off_in   = add_sum[SW-1:0];
            acc_in   = '0;
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Shift-add, multiplier bits taken MSB first
            acc_in  = add_sum[PW-1:0];
            off_in  = {off_ff[SW-2:0], 1'b0};
            step_in = step_ff + TW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            dev_in   = add_sum[UW] ? rmmmv_pkg::DEV_MAX : add_sum[UW-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff   <= '0;
         max_ff   <= '0;
         count_ff <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         count_ff <= count_in;
         mean_ff  <= mean_in;
         dev_ff   <= dev_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      up_ff     <= up_in;
      mag_ff    <= mag_in;
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      off_ff    <= off_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIFF))
      else $error("accepted beat did not start the sequence");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff != '0))
      else $error("divide with zero count");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) || (state_ff == ST_MUL)) |-> (step_ff <= LAST_STEP))
      else $error("step counter out of range");

   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |=> (dev_ff >= $past(dev_ff)))
      else $error("deviation sum decreased");

   a_mean_between: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEAN) |=>
         (up_ff ? (($signed(mean_ff) >= $signed($past(mean_ff)))
                   && ($signed(mean_ff) <= $signed(sample_ff)))
                : (($signed(mean_ff) <= $signed($past(mean_ff)))
                   && ($signed(mean_ff) >= $signed(sample_ff)))))
      else $error("new mean left the range between old mean and sample");
`endif

endmodule
